[sv/lkvc_pkg.sv]
// Shared types and constants of the LRU key to handle cache.
package lkvc_pkg;

  localparam int REQ_BITS = 2;
  localparam int CFG_BITS = 5;
  localparam logic [CFG_BITS-1:0] MAX_ENTRIES_RST = 5'd16;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_GET   = 2'd0,
    REQ_PUT   = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PROMOTE,
    CELL_INSERT,
    CELL_CLEAR
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     use_victim;
    logic     wr_key;
    logic     wr_handle;
  } cell_cmd_t;

endpackage

[sv/lkvc_req_if.sv]
// Request channel of the LRU key to handle cache.
interface lkvc_req_if #(
  parameter int KEY_BITS    = 48,
  parameter int HANDLE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic [lkvc_pkg::REQ_BITS-1:0] req_type;
  logic [KEY_BITS-1:0]           lookup_key;
  logic [HANDLE_BITS-1:0]        data_handle;

  modport source (output valid, req_type, lookup_key, data_handle, input ready);
  modport sink (input valid, req_type, lookup_key, data_handle, output ready);
endinterface

[sv/lkvc_rsp_if.sv]
// Response channel of the LRU key to handle cache.
interface lkvc_rsp_if #(
  parameter int KEY_BITS    = 48,
  parameter int HANDLE_BITS = 32,
  parameter int COUNT_BITS  = 32,
  parameter int OCC_BITS    = 5
);
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic [HANDLE_BITS-1:0] found_handle;
  logic                   evicted;
  logic [KEY_BITS-1:0]    evicted_key;
  logic [OCC_BITS-1:0]    occupancy;
  logic [COUNT_BITS-1:0]  hit_total;
  logic [COUNT_BITS-1:0]  miss_total;

  modport source (output valid, hit, found_handle, evicted, evicted_key, occupancy,
                  hit_total, miss_total, input ready);
  modport sink (input valid, hit, found_handle, evicted, evicted_key, occupancy,
                hit_total, miss_total, output ready);
endinterface

[sv/lkvc_cell.sv]
// One cache slot: key, handle and recency rank, with its link in the search chain.
module lkvc_cell #(
  parameter int ENTRIES     = 16,
  parameter int KEY_BITS    = 48,
  parameter int HANDLE_BITS = 32,
  parameter int IDX         = 0
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               capture_i,
  input  logic [KEY_BITS-1:0]                req_key_i,
  input  logic [$clog2(ENTRIES+1)-1:0]       live_count_i,
  input  lkvc_pkg::cell_cmd_t                cmd_i,
  input  logic [$clog2(ENTRIES)-1:0]         sel_rank_i,
  input  logic [KEY_BITS-1:0]                wr_key_i,
  input  logic [HANDLE_BITS-1:0]             wr_handle_i,
  input  logic                               match_i,
  input  logic                               victim_i,
  input  logic [HANDLE_BITS-1:0]             handle_i,
  input  logic [KEY_BITS-1:0]                key_i,
  input  logic [$clog2(ENTRIES)-1:0]         mrank_i,
  input  logic [$clog2(ENTRIES)-1:0]         vrank_i,
  output logic                               match_o,
  output logic                               victim_o,
  output logic [HANDLE_BITS-1:0]             handle_o,
  output logic [KEY_BITS-1:0]                key_o,
  output logic [$clog2(ENTRIES)-1:0]         mrank_o,
  output logic [$clog2(ENTRIES)-1:0]         vrank_o
);
  import lkvc_pkg::*;

  localparam int RankBits = $clog2(ENTRIES);
  localparam int OccBits  = $clog2(ENTRIES + 1);
  localparam logic [OccBits-1:0] MyIdx = OccBits'(IDX);

  logic [KEY_BITS-1:0]    key_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic [RankBits-1:0]    rank_q;
  logic                   match_q;
  logic                   victim_q;
  logic                   live;
  logic                   target;

  assign live   = MyIdx < live_count_i;
  assign target = cmd_i.use_victim ? victim_q : match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q   <= '0;
      match_q  <= 1'b0;
      victim_q <= 1'b0;
    end else begin
      if (capture_i) begin
        match_q  <= live && (key_q == req_key_i);
        victim_q <= live && (rank_q == RankBits'(live_count_i - OccBits'(1)));
      end
      case (cmd_i.op)
        CELL_PROMOTE: begin
          if (target) begin
            rank_q <= '0;
          end else if (live && (rank_q < sel_rank_i)) begin
            rank_q <= rank_q + RankBits'(1);
          end
        end
        CELL_INSERT: begin
          if (MyIdx == live_count_i) begin
            rank_q <= '0;
          end else if (live) begin
            rank_q <= rank_q + RankBits'(1);
          end
        end
        CELL_CLEAR: rank_q <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == CELL_PROMOTE && target) begin
      if (cmd_i.wr_key) begin
        key_q <= wr_key_i;
      end
      if (cmd_i.wr_handle) begin
        handle_q <= wr_handle_i;
      end
    end else if (cmd_i.op == CELL_INSERT && MyIdx == live_count_i) begin
      key_q    <= wr_key_i;
      handle_q <= wr_handle_i;
    end
  end

  assign match_o  = match_i | match_q;
  assign victim_o = victim_i | victim_q;
  assign handle_o = handle_i | (match_q ? handle_q : '0);
  assign key_o    = key_i | (victim_q ? key_q : '0);
  assign mrank_o  = mrank_i | (match_q ? rank_q : '0);
  assign vrank_o  = vrank_i | (victim_q ? rank_q : '0);

endmodule

[sv/lru_key_value_cache_unit.sv]
// Top level of the fully associative LRU key to handle cache.
// In the accept cycle every slot compares its key with the request key and checks whether
// it holds the oldest entry; in the execute state the slot results ripple along the row of
// cells, the request is resolved, all slots update their recency ranks together and the
// response is registered. A new request is taken only in the idle state, once the response
// register is free or being read, so none is taken while one is in progress. The max_entries
// register (reset 16) should only be written while no request is in progress, followed by a
// clear request.
module lru_key_value_cache_unit #(
  parameter int ENTRIES     = 16,
  parameter int KEY_BITS    = 48,
  parameter int HANDLE_BITS = 32,
  parameter int COUNT_BITS  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lkvc_pkg::CFG_BITS-1:0] cfg_wdata_i,
  lkvc_req_if.sink                      req,
  lkvc_rsp_if.source                    rsp
);
  import lkvc_pkg::*;

  localparam int RankBits = $clog2(ENTRIES);
  localparam int OccBits  = $clog2(ENTRIES + 1);
  localparam int CapBits  = (OccBits > CFG_BITS) ? OccBits : CFG_BITS;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                 state_q;
  logic [REQ_BITS-1:0]    req_type_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic [OccBits-1:0]     live_q, live_d;
  logic [COUNT_BITS-1:0]  hit_cnt_q, hit_cnt_d;
  logic [COUNT_BITS-1:0]  miss_cnt_q, miss_cnt_d;
  logic [CFG_BITS-1:0]    max_entries_q;

  logic                   rsp_valid_q;
  logic                   rsp_hit_q, res_hit;
  logic [HANDLE_BITS-1:0] rsp_found_q, res_found;
  logic                   rsp_ev_q, res_ev;
  logic [KEY_BITS-1:0]    rsp_evkey_q, res_evkey;

  logic                   accept;
  logic                   exec;
  cell_cmd_t              cmd;
  logic [RankBits-1:0]    sel_rank;
  logic [CapBits-1:0]     cap_raw, cap;
  logic                   full;

  logic [ENTRIES:0]       mchain;
  logic [ENTRIES:0]       vchain;
  logic [HANDLE_BITS-1:0] hchain [ENTRIES+1];
  logic [KEY_BITS-1:0]    kchain [ENTRIES+1];
  logic [RankBits-1:0]    mrchain [ENTRIES+1];
  logic [RankBits-1:0]    vrchain [ENTRIES+1];

  assign req.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign exec      = (state_q == ST_EXEC);

  assign mchain[0]  = 1'b0;
  assign vchain[0]  = 1'b0;
  assign hchain[0]  = '0;
  assign kchain[0]  = '0;
  assign mrchain[0] = '0;
  assign vrchain[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lkvc_cell #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .HANDLE_BITS(HANDLE_BITS),
      .IDX        (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .capture_i   (accept),
      .req_key_i   (req.lookup_key),
      .live_count_i(live_q),
      .cmd_i       (cmd),
      .sel_rank_i  (sel_rank),
      .wr_key_i    (key_q),
      .wr_handle_i (handle_q),
      .match_i     (mchain[g]),
      .victim_i    (vchain[g]),
      .handle_i    (hchain[g]),
      .key_i       (kchain[g]),
      .mrank_i     (mrchain[g]),
      .vrank_i     (vrchain[g]),
      .match_o     (mchain[g+1]),
      .victim_o    (vchain[g+1]),
      .handle_o    (hchain[g+1]),
      .key_o       (kchain[g+1]),
      .mrank_o     (mrchain[g+1]),
      .vrank_o     (vrchain[g+1])
    );
  end

  assign cap_raw = CapBits'(max_entries_q);
  assign cap     = (cap_raw == '0) ? CapBits'(1) :
                   ((cap_raw > CapBits'(ENTRIES)) ? CapBits'(ENTRIES) : cap_raw);
  assign full    = CapBits'(live_q) >= cap;

  assign sel_rank = cmd.use_victim ? vrchain[ENTRIES] : mrchain[ENTRIES];

  always_comb begin
    cmd        = '{op: CELL_HOLD, use_victim: 1'b0, wr_key: 1'b0, wr_handle: 1'b0};
    res_hit    = 1'b0;
    res_found  = '0;
    res_ev     = 1'b0;
    res_evkey  = '0;
    live_d     = live_q;
    hit_cnt_d  = hit_cnt_q;
    miss_cnt_d = miss_cnt_q;
    if (exec) begin
      unique case (req_type_q)
        REQ_GET: begin
          if (mchain[ENTRIES]) begin
            res_hit   = 1'b1;
            res_found = hchain[ENTRIES];
            cmd.op    = CELL_PROMOTE;
            if (hit_cnt_q != '1) begin
              hit_cnt_d = hit_cnt_q + COUNT_BITS'(1);
            end
          end else if (miss_cnt_q != '1) begin
            miss_cnt_d = miss_cnt_q + COUNT_BITS'(1);
          end
        end
        REQ_PUT: begin
          if (handle_q != '0) begin
            if (mchain[ENTRIES]) begin
              res_hit       = 1'b1;
              cmd.op        = CELL_PROMOTE;
              cmd.wr_handle = 1'b1;
            end else if (full) begin
              res_ev         = 1'b1;
              res_evkey      = kchain[ENTRIES];
              cmd.op         = CELL_PROMOTE;
              cmd.use_victim = 1'b1;
              cmd.wr_key     = 1'b1;
              cmd.wr_handle  = 1'b1;
            end else if (live_q < OccBits'(ENTRIES)) begin
              cmd.op = CELL_INSERT;
              live_d = live_q + OccBits'(1);
            end
          end
        end
        REQ_CLEAR: begin
          cmd.op     = CELL_CLEAR;
          live_d     = '0;
          hit_cnt_d  = '0;
          miss_cnt_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      live_q        <= '0;
      hit_cnt_q     <= '0;
      miss_cnt_q    <= '0;
      max_entries_q <= MAX_ENTRIES_RST;
      rsp_valid_q   <= 1'b0;
      rsp_hit_q     <= 1'b0;
      rsp_found_q   <= '0;
      rsp_ev_q      <= 1'b0;
      rsp_evkey_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        max_entries_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (rsp.ready) begin
            rsp_valid_q <= 1'b0;
          end
          if (accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q     <= ST_IDLE;
          live_q      <= live_d;
          hit_cnt_q   <= hit_cnt_d;
          miss_cnt_q  <= miss_cnt_d;
          rsp_valid_q <= 1'b1;
          rsp_hit_q   <= res_hit;
          rsp_found_q <= res_found;
          rsp_ev_q    <= res_ev;
          rsp_evkey_q <= res_evkey;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_type_q <= req.req_type;
      key_q      <= req.lookup_key;
      handle_q   <= req.data_handle;
    end
  end

  assign rsp.valid        = rsp_valid_q;
  assign rsp.hit          = rsp_hit_q;
  assign rsp.found_handle = rsp_found_q;
  assign rsp.evicted      = rsp_ev_q;
  assign rsp.evicted_key  = rsp_evkey_q;
  assign rsp.occupancy    = live_q;
  assign rsp.hit_total    = hit_cnt_q;
  assign rsp.miss_total   = miss_cnt_q;

endmodule

[tb/sv/tb_lru_key_value_cache_unit.sv]
// Self-checking testbench of the LRU key to handle cache against a shadow cache model.
module tb_lru_key_value_cache_unit;
  import lkvc_pkg::*;

  localparam int ENTRIES     = 16;
  localparam int KEY_BITS    = 48;
  localparam int HANDLE_BITS = 32;
  localparam int COUNT_BITS  = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [REQ_BITS-1:0] REQ_UNKNOWN = 2'd3;

  typedef struct {
    logic [REQ_BITS-1:0]    kind;
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
  } cache_req_t;

  typedef struct {
    logic                   hit;
    logic [HANDLE_BITS-1:0] found_handle;
    logic                   evicted;
    logic [KEY_BITS-1:0]    evicted_key;
    logic [4:0]             occupancy;
    logic [COUNT_BITS-1:0]  hit_total;
    logic [COUNT_BITS-1:0]  miss_total;
  } cache_rsp_t;

  class lru_shadow;
    logic [KEY_BITS-1:0]    keys[ENTRIES];
    logic [HANDLE_BITS-1:0] handles[ENTRIES];
    int unsigned            rank[ENTRIES];
    int unsigned            live;
    logic [COUNT_BITS-1:0]  hits;
    logic [COUNT_BITS-1:0]  misses;
    logic [CFG_BITS-1:0]    max_entries;
    int                     errors;
    cache_rsp_t             pending_rsp[$];

    function new();
      foreach (rank[i]) rank[i] = 0;
      live        = 0;
      hits        = '0;
      misses      = '0;
      max_entries = MAX_ENTRIES_RST;
      errors      = 0;
    endfunction

    function void set_max_entries(logic [CFG_BITS-1:0] v);
      max_entries = v;
    endfunction

    function int unsigned capacity();
      int unsigned c;
      c = max_entries;
      if (c < 1) c = 1;
      if (c > ENTRIES) c = ENTRIES;
      return c;
    endfunction

    function int find_slot(logic [KEY_BITS-1:0] key);
      for (int i = 0; i < live; i++) begin
        if (keys[i] == key) return i;
      end
      return -1;
    endfunction

    function void promote(int unsigned s);
      int unsigned r;
      r = rank[s];
      for (int i = 0; i < live; i++) begin
        if (rank[i] < r) rank[i]++;
      end
      rank[s] = 0;
    endfunction

    function void note_request(cache_req_t r);
      cache_rsp_t  e;
      int          s;
      int unsigned victim;
      e = '{hit: 1'b0, found_handle: '0, evicted: 1'b0, evicted_key: '0,
            occupancy: '0, hit_total: '0, miss_total: '0};
      case (r.kind)
        REQ_GET: begin
          s = find_slot(r.key);
          if (s >= 0) begin
            e.hit = 1'b1;
            e.found_handle = handles[s];
            promote(s);
            if (hits != '1) hits++;
          end else begin
            if (misses != '1) misses++;
          end
        end
        REQ_PUT: begin
          if (r.handle != '0) begin
            s = find_slot(r.key);
            if (s >= 0) begin
              e.hit = 1'b1;
              handles[s] = r.handle;
              promote(s);
            end else if (live >= capacity() && live > 0) begin
              victim = 0;
              for (int i = 0; i < live; i++) begin
                if (rank[i] == live - 1) victim = i;
              end
              e.evicted = 1'b1;
              e.evicted_key = keys[victim];
              promote(victim);
              keys[victim] = r.key;
              handles[victim] = r.handle;
            end else if (live < ENTRIES) begin
              for (int i = 0; i < live; i++) rank[i]++;
              keys[live] = r.key;
              handles[live] = r.handle;
              rank[live] = 0;
              live++;
            end
          end
        end
        REQ_CLEAR: begin
          foreach (rank[i]) rank[i] = 0;
          live   = 0;
          hits   = '0;
          misses = '0;
        end
        default: begin
        end
      endcase
      e.occupancy  = live[4:0];
      e.hit_total  = hits;
      e.miss_total = misses;
      pending_rsp.push_back(e);
    endfunction

    function void compare_field(string name, logic [63:0] e, logic [63:0] a);
      if (a !== e) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_response(cache_rsp_t a);
      cache_rsp_t e;
      if (pending_rsp.size() == 0) begin
        $display("%0t: response with no request waiting, actual occupancy %h", $time,
                 a.occupancy);
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        compare_field("hit", 64'(e.hit), 64'(a.hit));
        compare_field("found_handle", 64'(e.found_handle), 64'(a.found_handle));
        compare_field("evicted", 64'(e.evicted), 64'(a.evicted));
        compare_field("evicted_key", 64'(e.evicted_key), 64'(a.evicted_key));
        compare_field("occupancy", 64'(e.occupancy), 64'(a.occupancy));
        compare_field("hit_total", 64'(e.hit_total), 64'(a.hit_total));
        compare_field("miss_total", 64'(e.miss_total), 64'(a.miss_total));
      end
    endfunction

    function int left();
      return pending_rsp.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_BITS-1:0] cfg_wdata;
  int                  cycle_count;
  int                  burst_left;
  int                  stall_span;
  logic [15:0]         stall_mask;
  logic [KEY_BITS-1:0] key_pool[32];
  lru_shadow           shadow;

  logic [CFG_BITS-1:0] phase_cap[8]   = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd8, 5'd17, 5'd2};
  bit                  phase_clear[8] = '{1, 1, 0, 1, 0, 1, 0, 0};
  int                  phase_len[8]   = '{300, 200, 250, 250, 200, 250, 250, 200};
  int                  phase_pool[8]  = '{22, 3, 7, 24, 3, 12, 24, 5};

  lkvc_req_if #(.KEY_BITS(KEY_BITS), .HANDLE_BITS(HANDLE_BITS)) req_if ();
  lkvc_rsp_if #(.KEY_BITS(KEY_BITS), .HANDLE_BITS(HANDLE_BITS), .COUNT_BITS(COUNT_BITS),
                .OCC_BITS(5)) rsp_if ();

  lru_key_value_cache_unit #(
    .ENTRIES(ENTRIES),
    .KEY_BITS(KEY_BITS),
    .HANDLE_BITS(HANDLE_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_we_i(cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req(req_if),
    .rsp(rsp_if)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("lru_key_value_cache_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        shadow.check_response('{hit: rsp_if.hit, found_handle: rsp_if.found_handle,
                                evicted: rsp_if.evicted, evicted_key: rsp_if.evicted_key,
                                occupancy: rsp_if.occupancy, hit_total: rsp_if.hit_total,
                                miss_total: rsp_if.miss_total});
      end
      if (req_if.valid && req_if.ready) begin
        shadow.note_request('{kind: req_if.req_type, key: req_if.lookup_key,
                              handle: req_if.data_handle});
      end
    end
  end

  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_span <= $urandom_range(16, 96);
      case ($urandom_range(0, 3))
        0: stall_mask <= 16'hFFFF;
        1: stall_mask <= 16'hAAAA;
        default: stall_mask <= 16'($urandom) | 16'h0101;
      endcase
    end else begin
      stall_span <= stall_span - 1;
    end
    rsp_if.ready <= stall_mask[stall_span[3:0]];
  end

  task automatic send_request(input logic [REQ_BITS-1:0] kind, input logic [KEY_BITS-1:0] key,
                              input logic [HANDLE_BITS-1:0] handle);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        req_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    req_if.valid       <= 1'b1;
    req_if.req_type    <= kind;
    req_if.lookup_key  <= key;
    req_if.data_handle <= handle;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic drain_requests();
    @(negedge clk);
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (shadow.left() != 0) @(posedge clk);
  endtask

  task automatic write_max_entries(input logic [CFG_BITS-1:0] v);
    drain_requests();
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow.set_max_entries(v);
  endtask

  task automatic run_random_phase(input int count, input int pool_n);
    int                     pick;
    logic [REQ_BITS-1:0]    kind;
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) kind = REQ_GET;
      else if (pick < 93) kind = REQ_PUT;
      else if (pick < 96) kind = REQ_CLEAR;
      else kind = REQ_UNKNOWN;
      if ($urandom_range(0, 9) == 0) key = {16'($urandom), 32'($urandom)};
      else key = key_pool[$urandom_range(0, pool_n - 1)];
      pick = $urandom_range(0, 19);
      if (pick == 0) handle = '0;
      else if (pick == 1) handle = '1;
      else handle = $urandom;
      send_request(kind, key, handle);
    end
  endtask

  initial begin
    shadow             = new();
    clk                = 1'b0;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    cycle_count        = 0;
    burst_left         = 0;
    stall_span         = 0;
    stall_mask         = 16'hFFFF;
    rsp_if.ready       = 1'b0;
    req_if.valid       = 1'b0;
    req_if.req_type    = REQ_GET;
    req_if.lookup_key  = '0;
    req_if.data_handle = '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 32; i++) key_pool[i] = {16'($urandom), 32'($urandom)};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    send_request(REQ_GET, '0, 32'h1);
    send_request(REQ_PUT, '0, '1);
    send_request(REQ_PUT, '1, 32'h1);
    send_request(REQ_GET, '0, '0);
    send_request(REQ_GET, '1, '0);
    send_request(REQ_PUT, 48'h5, '0);
    send_request(REQ_PUT, '0, 32'hA5A5_A5A5);
    send_request(REQ_GET, '0, '0);
    send_request(REQ_UNKNOWN, '1, '1);
    send_request(REQ_CLEAR, '1, '1);
    send_request(REQ_GET, '0, '0);
    write_max_entries(5'd2);
    send_request(REQ_CLEAR, '0, '0);
    send_request(REQ_PUT, 48'h1234_5678_9ABC, 32'h1111_0001);
    send_request(REQ_PUT, 48'hFEDC_BA98_7654, 32'h2222_0002);
    send_request(REQ_GET, 48'h1234_5678_9ABC, '0);
    send_request(REQ_PUT, 48'h0F0F_0F0F_0F0F, 32'h3333_0003);
    send_request(REQ_PUT, 48'hF0F0_F0F0_F0F0, 32'h4444_0004);
    write_max_entries(5'd1);
    send_request(REQ_PUT, 48'h8000_0000_0001, 32'h8000_0000);
    send_request(REQ_GET, 48'hF0F0_F0F0_F0F0, '0);
    send_request(REQ_CLEAR, '0, '0);

    for (int p = 0; p < 8; p++) begin
      write_max_entries(phase_cap[p]);
      if (phase_clear[p]) send_request(REQ_CLEAR, '0, '0);
      run_random_phase(phase_len[p], phase_pool[p]);
    end

    drain_requests();
    repeat (20) @(posedge clk);
    if (shadow.errors == 0 && shadow.left() == 0) begin
      $display("lru_key_value_cache_unit verification clean");
    end else begin
      $display("lru_key_value_cache_unit verification failed");
    end
    $finish;
  end
endmodule

[sim.f]
sv/lkvc_pkg.sv
sv/lkvc_req_if.sv
sv/lkvc_rsp_if.sv
sv/lkvc_cell.sv
sv/lru_key_value_cache_unit.sv
tb/sv/tb_lru_key_value_cache_unit.sv
